// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// The clocked forms sample on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/vwir_pkg.sv =====
package vwir_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_BITS   = 16;
   localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
   localparam int INDEX_BITS   = 10;
   localparam int THRESH_BITS  = 36;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 36'd67;
   localparam int ENTRY_BITS   = 3 * COORD_BITS + ADDR_BITS;
   localparam int SQ_BITS      = 2 * COORD_BITS;
   localparam int SUM_BITS     = SQ_BITS + 2;
   localparam int CMP_BITS     = (SUM_BITS > THRESH_BITS) ? SUM_BITS : THRESH_BITS;
   localparam int RANGE_BITS   = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_REMAP = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NOT_LOADED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_run;
      logic lookup;
      logic write_entry;
      logic finish;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     table_full;
      logic     remap_lookup;
      logic     scan_done;
      logic     out_free;
   } sts_type;

endpackage

// ===== rtl/vwir_ram.sv =====
module vwir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/vwir_ctrl.sv =====
`include "assert_macros.svh"

module vwir_ctrl
   import vwir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.func == FUNC_ADD && !sts.table_full) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (sts.remap_lookup) begin
               cmd.lookup = 1'b1;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE, "controller not idle after reset")
   `ASSERT_CLK(a_scan_add, state_ff == ST_SCAN |-> sts.func == FUNC_ADD && !sts.table_full, "scan without a storable add")
   `ASSERT_CLK(a_done_holds, state_ff == ST_DONE && !sts.out_free |=> state_ff == ST_DONE, "result left before slot free")

endmodule

// ===== rtl/vwir_dp.sv =====
`include "assert_macros.svh"

module vwir_dp
   import vwir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   input  logic [1:0]                    req_func,
   input  logic signed [COORD_BITS-1:0]  req_vertex_x,
   input  logic signed [COORD_BITS-1:0]  req_vertex_y,
   input  logic signed [COORD_BITS-1:0]  req_vertex_z,
   input  logic [INDEX_BITS-1:0]         req_old_index,
   input  logic                          req_restart_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [INDEX_BITS-1:0]         rsp_new_index,
   output logic                          rsp_kept,
   output logic                          rsp_restart_out,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_wr_en,
   input  logic [THRESH_BITS-1:0]        csr_wr_data
);

   // Square of the exact difference of two coordinates.
   function automatic logic [SQ_BITS-1:0] diff_square(
      input logic [COORD_BITS-1:0] a,
      input logic [COORD_BITS-1:0] b
   );
      logic [COORD_BITS:0]   d;
      logic [COORD_BITS:0]   mag_w;
      logic [COORD_BITS-1:0] mag;
      d     = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      mag_w = d[COORD_BITS] ? (~d + 1'b1) : d;
      mag   = mag_w[COORD_BITS-1:0];
      return SQ_BITS'(mag) * SQ_BITS'(mag);
   endfunction

   // Item latched at acceptance.
   func_type                  func_ff, func_in;
   logic [COORD_BITS-1:0]     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [INDEX_BITS-1:0]     old_ff, old_in;
   logic                      restart_ff, restart_in;
   logic                      full_ff, full_in;
   logic                      in_range_ff, in_range_in;

   // Table state and scan control.
   logic [THRESH_BITS-1:0]    thr_ff, thr_in;
   logic [CNT_BITS-1:0]       vertex_count_ff, vertex_count_in;
   logic [CNT_BITS-1:0]       unique_count_ff, unique_count_in;
   logic [CNT_BITS-1:0]       scan_addr_ff, scan_addr_in;
   logic                      v1_ff, v1_in, v2_ff, v2_in;
   logic                      match_ff, match_in;
   logic [ADDR_BITS-1:0]      match_idx_ff, match_idx_in;
   logic [ADDR_BITS-1:0]      assigned_idx_ff, assigned_idx_in;
   logic [SQ_BITS-1:0]        sq_x_ff, sq_x_in, sq_y_ff, sq_y_in, sq_z_ff, sq_z_in;
   logic [ADDR_BITS-1:0]      idx2_ff, idx2_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]     new_index_ff, new_index_in;
   logic                      kept_ff, kept_in;
   logic                      restart_out_ff, restart_out_in;
   status_type                status_ff, status_in;

   logic                      scan_issue;
   logic                      issued_all;
   logic                      hit;
   logic [SUM_BITS-1:0]       dist_sum;
   logic [ADDR_BITS-1:0]      new_idx;
   logic                      rd_en;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic [ENTRY_BITS-1:0]     rd_data;
   logic [ENTRY_BITS-1:0]     wr_data;
   logic [ADDR_BITS-1:0]      rd_idx;

   assign issued_all = (scan_addr_ff == vertex_count_ff);
   assign scan_issue = cmd.scan_run && !match_ff && !issued_all;
   assign dist_sum   = SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff) + SUM_BITS'(sq_z_ff);
   assign hit        = v2_ff && (CMP_BITS'(dist_sum) <= CMP_BITS'(thr_ff));
   assign new_idx    = match_ff ? match_idx_ff : unique_count_ff[ADDR_BITS-1:0];
   assign rd_en      = scan_issue || cmd.lookup;
   assign rd_addr    = cmd.lookup ? ADDR_BITS'(old_ff) : scan_addr_ff[ADDR_BITS-1:0];
   assign wr_data    = {new_idx, z_ff, y_ff, x_ff};
   assign rd_idx     = rd_data[ENTRY_BITS-1 -: ADDR_BITS];

   vwir_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (vertex_count_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      func_in         = func_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      z_in            = z_ff;
      old_in          = old_ff;
      restart_in      = restart_ff;
      full_in         = full_ff;
      in_range_in     = in_range_ff;
      thr_in          = thr_ff;
      vertex_count_in = vertex_count_ff;
      unique_count_in = unique_count_ff;
      scan_addr_in    = scan_addr_ff;
      v1_in           = scan_issue;
      v2_in           = v1_ff;
      match_in        = match_ff;
      match_idx_in    = match_idx_ff;
      assigned_idx_in = assigned_idx_ff;
      idx2_in         = rd_idx;
      sq_x_in         = diff_square(x_ff, rd_data[COORD_BITS-1:0]);
      sq_y_in         = diff_square(y_ff, rd_data[2*COORD_BITS-1:COORD_BITS]);
      sq_z_in         = diff_square(z_ff, rd_data[3*COORD_BITS-1:2*COORD_BITS]);
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      new_index_in    = new_index_ff;
      kept_in         = kept_ff;
      restart_out_in  = restart_out_ff;
      status_in       = status_ff;

      if (csr_wr_en) begin
         thr_in = csr_wr_data;
      end

      if (cmd.accept) begin
         func_in     = func_type'(req_func);
         x_in        = req_vertex_x;
         y_in        = req_vertex_y;
         z_in        = req_vertex_z;
         old_in      = req_old_index;
         restart_in  = req_restart_in;
         full_in     = (vertex_count_ff == CNT_BITS'(MAX_VERTICES));
         in_range_in = (RANGE_BITS'(req_old_index) < RANGE_BITS'(vertex_count_ff));
      end

      if (cmd.scan_start) begin
         scan_addr_in = '0;
         match_in     = 1'b0;
         v1_in        = 1'b0;
         v2_in        = 1'b0;
      end else begin
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         // The pipeline is in order, so the first hit is the earliest vertex.
         if (hit && !match_ff) begin
            match_in     = 1'b1;
            match_idx_in = idx2_ff;
         end
      end

      if (cmd.write_entry) begin
         assigned_idx_in = new_idx;
         vertex_count_in = vertex_count_ff + 1'b1;
         if (!match_ff) begin
            unique_count_in = unique_count_ff + 1'b1;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         new_index_in   = '0;
         kept_in        = 1'b0;
         restart_out_in = 1'b0;
         status_in      = STATUS_OK;
         case (func_ff)
            FUNC_ADD: begin
               if (full_ff) begin
                  status_in = STATUS_FULL;
               end else begin
                  new_index_in = INDEX_BITS'(assigned_idx_ff);
                  kept_in      = !match_ff;
               end
            end
            FUNC_REMAP: begin
               restart_out_in = restart_ff;
               if (restart_ff) begin
                  new_index_in = old_ff;
               end else if (in_range_ff) begin
                  new_index_in = INDEX_BITS'(rd_idx);
               end else begin
                  status_in = STATUS_NOT_LOADED;
               end
            end
            FUNC_CLEAR: begin
               vertex_count_in = '0;
               unique_count_in = '0;
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff          <= THRESH_RESET;
         vertex_count_ff <= '0;
         unique_count_ff <= '0;
         scan_addr_ff    <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         match_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         thr_ff          <= thr_in;
         vertex_count_ff <= vertex_count_in;
         unique_count_ff <= unique_count_in;
         scan_addr_ff    <= scan_addr_in;
         v1_ff           <= v1_in;
         v2_ff           <= v2_in;
         match_ff        <= match_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      z_ff            <= z_in;
      old_ff          <= old_in;
      restart_ff      <= restart_in;
      full_ff         <= full_in;
      in_range_ff     <= in_range_in;
      match_idx_ff    <= match_idx_in;
      assigned_idx_ff <= assigned_idx_in;
      idx2_ff         <= idx2_in;
      sq_x_ff         <= sq_x_in;
      sq_y_ff         <= sq_y_in;
      sq_z_ff         <= sq_z_in;
      new_index_ff    <= new_index_in;
      kept_ff         <= kept_in;
      restart_out_ff  <= restart_out_in;
      status_ff       <= status_in;
   end

   assign sts.func         = func_ff;
   assign sts.table_full   = full_ff;
   assign sts.remap_lookup = (func_ff == FUNC_REMAP) && !restart_ff && in_range_ff;
   assign sts.scan_done    = match_ff || (issued_all && !v1_ff && !v2_ff);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_index   = new_index_ff;
   assign rsp_kept        = kept_ff;
   assign rsp_restart_out = restart_out_ff;
   assign rsp_status      = status_ff;

   `ASSERT_CLK(a_write_room, cmd.write_entry |-> vertex_count_ff < CNT_BITS'(MAX_VERTICES), "vertex written into a full table")
   `ASSERT_CLK(a_scan_bound, scan_issue |-> scan_addr_ff < vertex_count_ff, "scan read past stored vertices")

endmodule

// ===== rtl/vertex_weld_index_remap.sv =====
// Vertex welding and index renumbering.
// The req channel carries one command per beat: add a vertex, remap an
// old index, or clear the table. Each beat produces exactly one rsp beat
// with the compacted index, the kept flag, the echoed restart marker and
// a status code. The threshold register is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. It resets to 67. An add compares
// the vertex against every stored vertex, one stored vertex per cycle
// read from the vertex memory, and stops at the first match. The scan
// reads in address order through the memory read register and the
// squared-difference registers, and a hit stops further reads. Remap,
// clear and full-table adds skip the scan and go from dispatch to done.
// One command is worked on at a time. The result sits in an output
// register, so the next command is accepted while the previous result
// still waits for rsp_ready; a finished result is held until the
// register is free. Synchronous reset empties the table and clears
// the valid flags; it needs no clearing pass.
module vertex_weld_index_remap
   import vwir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic signed [COORD_BITS-1:0]  req_vertex_x,
   input  logic signed [COORD_BITS-1:0]  req_vertex_y,
   input  logic signed [COORD_BITS-1:0]  req_vertex_z,
   input  logic [INDEX_BITS-1:0]         req_old_index,
   input  logic                          req_restart_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [INDEX_BITS-1:0]         rsp_new_index,
   output logic                          rsp_kept,
   output logic                          rsp_restart_out,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_wr_en,
   input  logic [THRESH_BITS-1:0]        csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   vwir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vwir_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_vertex_z    (req_vertex_z),
      .req_old_index   (req_old_index),
      .req_restart_in  (req_restart_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_index   (rsp_new_index),
      .rsp_kept        (rsp_kept),
      .rsp_restart_out (rsp_restart_out),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

endmodule
